// ----- hw/rtl/ltop_pkg.sv -----
// Package with shared types, widths, register indexes and stage counts of the order block.
`default_nettype none

package ltop_pkg;

    // One transaction on the input side: three tail-carbon positions, Q7.16 nm.
    typedef struct packed {
        logic signed [23:0] prev_x;
        logic signed [23:0] prev_y;
        logic signed [23:0] prev_z;
        logic signed [23:0] cur_x;
        logic signed [23:0] cur_y;
        logic signed [23:0] cur_z;
        logic signed [23:0] next_x;
        logic signed [23:0] next_y;
        logic signed [23:0] next_z;
    } item_t;

    // One transaction on the output side.
    typedef struct packed {
        logic signed [15:0] order_sx;
        logic signed [15:0] order_sy;
        logic signed [15:0] order_sz;
        logic [7:0]         slice_index;
        logic               degenerate;
    } result_t;

    // Vector components leave the geometry stages 51 bits wide, two's complement.
    localparam int VecW = 51;
    typedef logic [2:0][VecW-1:0] vec_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] REG_NORMAL_AXIS = 3'd0;
    localparam logic [2:0] REG_SLICE_COUNT = 3'd1;
    localparam logic [2:0] REG_BOX_LENGTH  = 3'd2;
    localparam logic [2:0] REG_SLICING_ON  = 3'd3;

    // Register stages of each unit.
    localparam int LAT_GEOM  = 3;
    localparam int LAT_TERM  = 20;
    localparam int LAT_SLICE = 21;
    localparam int LAT_ORDER = LAT_GEOM + LAT_TERM;

endpackage

`default_nettype wire

// ----- hw/rtl/ltop_geom.sv -----
// Geometry stages: bond differences, cross product and the zero-vector flag.
`default_nettype none

module ltop_geom (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire ltop_pkg::item_t item,
    output ltop_pkg::vec_t      xv,
    output ltop_pkg::vec_t      dv,
    output logic                degen
);

    logic signed [24:0] d1_reg [0:2];
    logic signed [24:0] t1_reg [0:2];
    logic signed [24:0] t2_reg [0:2];
    logic signed [24:0] d2_reg [0:2];
    logic signed [49:0] prod_reg [0:5];
    ltop_pkg::vec_t     x_reg;
    ltop_pkg::vec_t     d3_reg;
    logic               degen_reg;

    logic [23:0] p [0:2];
    logic [23:0] c [0:2];
    logic [23:0] n [0:2];
    ltop_pkg::vec_t x_next;

    assign p[0] = item.prev_x;
    assign p[1] = item.prev_y;
    assign p[2] = item.prev_z;
    assign c[0] = item.cur_x;
    assign c[1] = item.cur_y;
    assign c[2] = item.cur_z;
    assign n[0] = item.next_x;
    assign n[1] = item.next_y;
    assign n[2] = item.next_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= $signed({n[i][23], n[i]} - {p[i][23], p[i]});
                t1_reg[i] <= $signed({n[i][23], n[i]} - {c[i][23], c[i]});
                t2_reg[i] <= $signed({p[i][23], p[i]} - {c[i][23], c[i]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= t1_reg[1] * t2_reg[2];
            prod_reg[1] <= t1_reg[2] * t2_reg[1];
            prod_reg[2] <= t1_reg[2] * t2_reg[0];
            prod_reg[3] <= t1_reg[0] * t2_reg[2];
            prod_reg[4] <= t1_reg[0] * t2_reg[1];
            prod_reg[5] <= t1_reg[1] * t2_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                d2_reg[i] <= d1_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            x_next[i] = {prod_reg[2*i][49], prod_reg[2*i]}
                      - {prod_reg[2*i+1][49], prod_reg[2*i+1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            for (int i = 0; i < 3; i++)
            begin
                d3_reg[i] <= {{(ltop_pkg::VecW-25){d2_reg[i][24]}}, d2_reg[i]};
            end
            degen_reg <= ((d2_reg[0] == '0) && (d2_reg[1] == '0) && (d2_reg[2] == '0))
                      || (x_next == '0);
        end
    end

    assign xv    = x_reg;
    assign dv    = d3_reg;
    assign degen = degen_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ltop_term.sv -----
// Order term unit: magnitude, normalizing shift, squares and a pipelined quotient.
`default_nettype none

module ltop_term (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire ltop_pkg::vec_t vec,
    input  wire logic [1:0]     axis,
    output logic [14:0]         quotient
);

    localparam int W = ltop_pkg::VecW;
    localparam int QuoW = 15;

    ltop_pkg::vec_t mag1_reg;
    logic [W-1:0]   or1_reg;
    ltop_pkg::vec_t mag2_reg;
    logic [W-1:0]   or2_reg;
    logic [2:0][22:0] r3_reg;
    logic [45:0]    sq_reg [0:2];
    logic [62:0]    rem_reg [0:QuoW];
    logic [48:0]    den_reg [0:QuoW];
    logic [14:0]    quo_reg [0:QuoW];

    ltop_pkg::vec_t mag_next;
    ltop_pkg::vec_t r2_next;
    logic [W-1:0]   v2_next;
    ltop_pkg::vec_t r3_next;
    logic [W-1:0]   v3_next;
    logic [47:0]    s_next;
    logic [45:0]    q_sel;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = vec[i][W-1] ? (W'(0) - vec[i]) : vec[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag_next;
            or1_reg  <= mag_next[0] | mag_next[1] | mag_next[2];
        end
    end

    // The shift that brings the largest magnitude below 2^23 is found one bit at a time.
    always_comb
    begin
        v2_next = or1_reg;
        r2_next = mag1_reg;
        for (int k = 4; k >= 2; k--)
        begin
            if ((v2_next >> (22 + (1 << k))) != '0)
            begin
                v2_next = v2_next >> (1 << k);
                for (int i = 0; i < 3; i++)
                begin
                    r2_next[i] = r2_next[i] >> (1 << k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag2_reg <= r2_next;
            or2_reg  <= v2_next;
        end
    end

    always_comb
    begin
        v3_next = or2_reg;
        r3_next = mag2_reg;
        for (int k = 1; k >= 0; k--)
        begin
            if ((v3_next >> (22 + (1 << k))) != '0)
            begin
                v3_next = v3_next >> (1 << k);
                for (int i = 0; i < 3; i++)
                begin
                    r3_next[i] = r3_next[i] >> (1 << k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r3_reg[i] <= r3_next[i][22:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= r3_reg[i] * r3_reg[i];
            end
        end
    end

    always_comb
    begin
        s_next = 48'(sq_reg[0]) + 48'(sq_reg[1]) + 48'(sq_reg[2]);
        case (axis)
            ltop_pkg::AXIS_X: q_sel = sq_reg[0];
            ltop_pkg::AXIS_Y: q_sel = sq_reg[1];
            default:          q_sel = sq_reg[2];
        endcase
    end

    // Numerator 3*q*2^14 + s over 2*s gives the rounded term plus 8192.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ((63'(q_sel) << 15) + (63'(q_sel) << 14)) + 63'(s_next);
            den_reg[0] <= {s_next, 1'b0};
            quo_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < QuoW; j++)
    begin : g_div
        localparam int K = QuoW - 1 - j;
        logic [63:0] trial;
        assign trial = 64'(den_reg[j]) << K;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j+1] <= den_reg[j];
                if (64'(rem_reg[j]) >= trial)
                begin
                    rem_reg[j+1] <= 63'(64'(rem_reg[j]) - trial);
                    quo_reg[j+1] <= quo_reg[j] | (15'd1 << K);
                end
                else
                begin
                    rem_reg[j+1] <= rem_reg[j];
                    quo_reg[j+1] <= quo_reg[j];
                end
            end
        end
    end

    assign quotient = quo_reg[QuoW];

endmodule

`default_nettype wire

// ----- hw/rtl/ltop_slice.sv -----
// Slice unit: wraps the midpoint into the box and scales it to a slice number.
`default_nettype none

module ltop_slice (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [23:0] prev_a,
    input  wire logic [23:0] next_a,
    input  wire logic [23:0] span,
    input  wire logic [8:0]  count,
    output logic [7:0]       slice
);

    localparam int ModStages = 13;
    localparam int DivStages = 4;

    logic [24:0] sum_reg;
    logic        neg_reg [0:ModStages];
    logic [24:0] mrem_reg [0:ModStages];
    logic [23:0] w_reg;
    logic [32:0] drem_reg [0:DivStages];
    logic [7:0]  dquo_reg [0:DivStages];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg     <= {prev_a[23], prev_a} + {next_a[23], next_a};
            neg_reg[0]  <= sum_reg[24];
            mrem_reg[0] <= sum_reg[24] ? (25'd0 - sum_reg) : sum_reg;
        end
    end

    // Restoring remainder of the magnitude, two bits a stage.
    for (genvar j = 0; j < ModStages; j++)
    begin : g_mod
        localparam int K1 = 24 - 2 * j;
        localparam int K2 = 23 - 2 * j;
        logic [24:0] a;
        logic [24:0] b;
        always_comb
        begin
            a = mrem_reg[j];
            if (49'(a) >= (49'(span) << K1))
            begin
                a = 25'(49'(a) - (49'(span) << K1));
            end
        end
        if (K2 >= 0)
        begin : g_two
            always_comb
            begin
                b = a;
                if (49'(a) >= (49'(span) << K2))
                begin
                    b = 25'(49'(a) - (49'(span) << K2));
                end
            end
        end
        else
        begin : g_one
            assign b = a;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mrem_reg[j+1] <= b;
                neg_reg[j+1]  <= neg_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[ModStages] && (mrem_reg[ModStages] != '0))
            begin
                w_reg <= 24'(25'(span) - mrem_reg[ModStages]);
            end
            else
            begin
                w_reg <= mrem_reg[ModStages][23:0];
            end
            drem_reg[0] <= w_reg * count;
            dquo_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < DivStages; j++)
    begin : g_div
        localparam int K1 = 7 - 2 * j;
        localparam int K2 = 6 - 2 * j;
        logic [32:0] a;
        logic [32:0] b;
        logic [7:0]  qa;
        logic [7:0]  qb;
        always_comb
        begin
            a  = drem_reg[j];
            qa = dquo_reg[j];
            if (34'(a) >= (34'(span) << K1))
            begin
                a  = 33'(34'(a) - (34'(span) << K1));
                qa = qa | (8'd1 << K1);
            end
            b  = a;
            qb = qa;
            if (34'(a) >= (34'(span) << K2))
            begin
                b  = 33'(34'(a) - (34'(span) << K2));
                qb = qb | (8'd1 << K2);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[j+1] <= b;
                dquo_reg[j+1] <= qb;
            end
        end
    end

    assign slice = dquo_reg[DivStages];

endmodule

`default_nettype wire

// ----- hw/rtl/lipid_tail_order_parameter.sv -----
// Top level of the lipid tail order block: configuration, pipeline control and output stage.
`default_nettype none

// Each input transaction carries three consecutive tail-carbon positions; each
// output transaction carries the Q1.14 order terms of the Sx, Sy and Sz axes
// along the configured membrane normal, the slice of the previous/next midpoint
// and a flag for a zero-length chain vector or cross product (terms are then
// zero). The block is a 24-stage pipeline: a new transaction is accepted every
// cycle while the pipeline is not held, and its depth is set by the
// order-term path: three geometry stages, five stages of magnitude, normalizing
// shift, squares and numerator, and a fifteen-stage divider that yields one
// quotient bit per stage, plus the output register. The slice path (a two-bit-
// per-stage wrap into the box and an eight-bit scaling divide) is shorter and is
// delayed to line up. When the result is not taken the whole pipeline holds, so
// nothing is dropped or repeated. Configuration writes take effect at once and
// are meant to happen only while no transaction is in flight.

module lipid_tail_order_parameter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire ltop_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output ltop_pkg::result_t      result,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [22:0]       cfg_data
);

    localparam int Lat   = ltop_pkg::LAT_ORDER;
    localparam int SlPad = ltop_pkg::LAT_ORDER - ltop_pkg::LAT_SLICE;
    localparam int DgPad = ltop_pkg::LAT_TERM;

    // Configuration registers.
    logic [1:0]  normal_axis_reg;
    logic [8:0]  slice_count_reg;
    logic [22:0] box_length_reg;
    logic        slicing_on_reg;

    logic [Lat-1:0]    valid_reg;
    logic              out_valid_reg;
    ltop_pkg::result_t out_reg;
    logic [7:0]        slice_dly_reg [0:SlPad-1];
    logic              degen_dly_reg [0:DgPad-1];

    logic        en;
    logic [1:0]  axis;
    logic [8:0]  count;
    logic [22:0] len;
    logic [23:0] span;
    logic [23:0] prev_a;
    logic [23:0] next_a;

    ltop_pkg::vec_t xv;
    ltop_pkg::vec_t dv;
    logic           degen_geom;
    logic [14:0]    quo_x;
    logic [14:0]    quo_z;
    logic [7:0]     slice_raw;

    logic signed [16:0] term_x;
    logic signed [16:0] term_z;
    logic signed [16:0] term_y;
    ltop_pkg::result_t  out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_axis_reg <= ltop_pkg::AXIS_Z;
            slice_count_reg <= 9'd1;
            box_length_reg  <= 23'd65536;
            slicing_on_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ltop_pkg::REG_NORMAL_AXIS: normal_axis_reg <= cfg_data[1:0];
                ltop_pkg::REG_SLICE_COUNT: slice_count_reg <= cfg_data[8:0];
                ltop_pkg::REG_BOX_LENGTH:  box_length_reg  <= cfg_data;
                ltop_pkg::REG_SLICING_ON:  slicing_on_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Out-of-range settings are folded into their legal range here.
    always_comb
    begin
        axis  = (normal_axis_reg == 2'd3) ? ltop_pkg::AXIS_Z : normal_axis_reg;
        if (slice_count_reg == '0)
        begin
            count = 9'd1;
        end
        else if (slice_count_reg > 9'd256)
        begin
            count = 9'd256;
        end
        else
        begin
            count = slice_count_reg;
        end
        len  = (box_length_reg == '0) ? 23'd1 : box_length_reg;
        span = {len, 1'b0};
        case (axis)
            ltop_pkg::AXIS_X:
            begin
                prev_a = item.prev_x;
                next_a = item.next_x;
            end
            ltop_pkg::AXIS_Y:
            begin
                prev_a = item.prev_y;
                next_a = item.next_y;
            end
            default:
            begin
                prev_a = item.prev_z;
                next_a = item.next_z;
            end
        endcase
    end

    // The pipeline moves as one whenever the output register is free or being emptied.
    assign en         = !out_valid_reg || result_ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[Lat-2:0], item_valid};
            out_valid_reg <= valid_reg[Lat-1];
        end
    end

    ltop_geom u_geom (
        .clk   (clk),
        .en    (en),
        .item  (item),
        .xv    (xv),
        .dv    (dv),
        .degen (degen_geom)
    );

    ltop_term u_term_x (
        .clk      (clk),
        .en       (en),
        .vec      (xv),
        .axis     (axis),
        .quotient (quo_x)
    );

    ltop_term u_term_z (
        .clk      (clk),
        .en       (en),
        .vec      (dv),
        .axis     (axis),
        .quotient (quo_z)
    );

    ltop_slice u_slice (
        .clk    (clk),
        .en     (en),
        .prev_a (prev_a),
        .next_a (next_a),
        .span   (span),
        .count  (count),
        .slice  (slice_raw)
    );

    // Align the slice number and the zero-vector flag with the order terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slice_dly_reg[0] <= slice_raw;
            for (int i = 1; i < SlPad; i++)
            begin
                slice_dly_reg[i] <= slice_dly_reg[i-1];
            end
            degen_dly_reg[0] <= degen_geom;
            for (int i = 1; i < DgPad; i++)
            begin
                degen_dly_reg[i] <= degen_dly_reg[i-1];
            end
        end
    end

    // Sy follows from orthonormality of the three axes, clamped to the term range.
    always_comb
    begin
        term_x = $signed({2'b00, quo_x}) - 17'sd8192;
        term_z = $signed({2'b00, quo_z}) - 17'sd8192;
        term_y = 17'sd0 - (term_x + term_z);
        if (term_y < -17'sd8192)
        begin
            term_y = -17'sd8192;
        end
        if (term_y > 17'sd16384)
        begin
            term_y = 17'sd16384;
        end
        if (degen_dly_reg[DgPad-1])
        begin
            out_next.order_sx = '0;
            out_next.order_sy = '0;
            out_next.order_sz = '0;
        end
        else
        begin
            out_next.order_sx = term_x[15:0];
            out_next.order_sy = term_y[15:0];
            out_next.order_sz = term_z[15:0];
        end
        out_next.slice_index = slicing_on_reg ? slice_dly_reg[SlPad-1] : 8'd0;
        out_next.degenerate  = degen_dly_reg[DgPad-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- dv/ltop_checker.sv -----
// Checker that predicts the lipid tail order results and compares them on the output channel.
`timescale 1ns / 100ps

module ltop_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_ready,
    input  wire ltop_pkg::item_t   item,
    input  wire logic              result_valid,
    input  wire logic              result_ready,
    input  wire ltop_pkg::result_t result,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [22:0]       cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     result_count,
    output int                     degen_count
);

    logic [1:0]        axis_reg;
    logic [8:0]        count_reg;
    logic [22:0]       length_reg;
    logic              slicing_reg;
    ltop_pkg::result_t expected_results[$];

    // Order term of a nonzero vector along axis ax, rounded to Q1.14.
    function automatic longint order_of(input longint v0, input longint v1,
                                        input longint v2, input int ax);
        longint unsigned r[3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned q;
        int sh;
        r[0] = (v0 < 0) ? -v0 : v0;
        r[1] = (v1 < 0) ? -v1 : v1;
        r[2] = (v2 < 0) ? -v2 : v2;
        m = r[0];
        if (r[1] > m) m = r[1];
        if (r[2] > m) m = r[2];
        sh = 0;
        while ((m >> sh) >= 64'd8388608) sh++;
        for (int i = 0; i < 3; i++) r[i] = r[i] >> sh;
        s = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        q = r[ax] * r[ax];
        if (s == 0) return 0;
        return longint'((3 * q * 16384 + s) / (2 * s)) - 8192;
    endfunction

    function automatic ltop_pkg::result_t predict_order(input ltop_pkg::item_t it);
        ltop_pkg::result_t rs;
        longint p[3], c[3], n[3], d[3], t1[3], t2[3], x[3];
        longint sx, sy, sz, sum;
        longint unsigned cnt, len, span, w, sl;
        int ax;
        ax = (axis_reg > 2) ? 2 : int'(axis_reg);
        p[0] = it.prev_x; p[1] = it.prev_y; p[2] = it.prev_z;
        c[0] = it.cur_x;  c[1] = it.cur_y;  c[2] = it.cur_z;
        n[0] = it.next_x; n[1] = it.next_y; n[2] = it.next_z;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = n[i] - p[i];
            t1[i] = n[i] - c[i];
            t2[i] = p[i] - c[i];
        end
        x[0] = t1[1] * t2[2] - t1[2] * t2[1];
        x[1] = t1[2] * t2[0] - t1[0] * t2[2];
        x[2] = t1[0] * t2[1] - t1[1] * t2[0];
        rs.degenerate = (d[0] == 0 && d[1] == 0 && d[2] == 0) ||
                        (x[0] == 0 && x[1] == 0 && x[2] == 0);
        sx = 0; sy = 0; sz = 0;
        if (!rs.degenerate)
        begin
            sx = order_of(x[0], x[1], x[2], ax);
            sz = order_of(d[0], d[1], d[2], ax);
            sy = -(sx + sz);
            if (sy < -8192) sy = -8192;
            if (sy > 16384) sy = 16384;
        end
        sl = 0;
        if (slicing_reg)
        begin
            cnt = count_reg;
            len = length_reg;
            if (cnt == 0) cnt = 1;
            if (cnt > 256) cnt = 256;
            if (len == 0) len = 1;
            span = 2 * len;
            sum = p[ax] + n[ax];
            if (sum >= 0)
                w = longint'(sum) % span;
            else
            begin
                w = longint'(-sum) % span;
                if (w != 0) w = span - w;
            end
            sl = (w * cnt) / span;
            if (sl > 255) sl = 255;
        end
        rs.order_sx = sx[15:0];
        rs.order_sy = sy[15:0];
        rs.order_sz = sz[15:0];
        rs.slice_index = sl[7:0];
        return rs;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        ltop_pkg::result_t want;
        if (!rst_n)
        begin
            axis_reg <= ltop_pkg::AXIS_Z;
            count_reg <= 9'd1;
            length_reg <= 23'd65536;
            slicing_reg <= 1'b0;
            expected_results.delete();
            fail_count = 0;
            result_count <= 0;
            degen_count <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_results.push_back(predict_order(item));
            if (result_valid && result_ready)
            begin
                result_count <= result_count + 1;
                if (result.degenerate) degen_count <= degen_count + 1;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.order_sx !== want.order_sx)
                        report_mismatch("order_sx", result.order_sx, want.order_sx);
                    if (result.order_sy !== want.order_sy)
                        report_mismatch("order_sy", result.order_sy, want.order_sy);
                    if (result.order_sz !== want.order_sz)
                        report_mismatch("order_sz", result.order_sz, want.order_sz);
                    if (result.slice_index !== want.slice_index)
                        report_mismatch("slice_index", result.slice_index, want.slice_index);
                    if (result.degenerate !== want.degenerate)
                        report_mismatch("degenerate", result.degenerate, want.degenerate);
                end
            end
            // Registers change only while idle, so updating after the prediction is safe.
            if (cfg_we)
            begin
                case (cfg_index)
                    ltop_pkg::REG_NORMAL_AXIS: axis_reg <= cfg_data[1:0];
                    ltop_pkg::REG_SLICE_COUNT: count_reg <= cfg_data[8:0];
                    ltop_pkg::REG_BOX_LENGTH:  length_reg <= cfg_data;
                    ltop_pkg::REG_SLICING_ON:  slicing_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- dv/tb_lipid_tail_order_parameter.sv -----
// Testbench top: stimulus, configuration phases and verdict for the lipid tail order block.
`timescale 1ns / 100ps

module tb_lipid_tail_order_parameter;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    ltop_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    ltop_pkg::result_t result;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [22:0]       cfg_data;
    int                fail_count;
    int                pending;
    int                result_count;
    int                degen_count;

    // Idling and receiver stalls are switched off during one long stretch of each slicing phase.
    logic        steady;

    // The clock runs at 2 ns.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lipid_tail_order_parameter dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ltop_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .result_count(result_count), .degen_count(degen_count)
    );

    // The receiver stalls at random, with a chance of about 15 in a hundred, unless steady.
    always @(posedge clk)
    begin
        result_ready <= steady || ($urandom_range(99) >= 15);
    end

    // Pick a coordinate: mostly small, sometimes at or near the extremes.
    function automatic logic [23:0] pick_coord();
        case ($urandom_range(9))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom);
            3, 4: return 24'($signed($urandom_range(511)) - 256);
            default: return 24'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    // Send one transaction; valid stays high through the handshake.
    task automatic send_item(input ltop_pkg::item_t it, input bit may_idle);
        if (may_idle && !steady)
        begin
            while ($urandom_range(99) < 15)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic send_random();
        ltop_pkg::item_t it;
        it.prev_x = pick_coord(); it.prev_y = pick_coord(); it.prev_z = pick_coord();
        it.cur_x = pick_coord();  it.cur_y = pick_coord();  it.cur_z = pick_coord();
        it.next_x = pick_coord(); it.next_y = pick_coord(); it.next_z = pick_coord();
        case ($urandom_range(19))
            // A repeated end coordinate, or a whole repeated end atom that gives a zero chain vector.
            0: it.next_x = it.prev_x;
            1:
            begin
                it.next_x = it.prev_x; it.next_y = it.prev_y; it.next_z = it.prev_z;
            end
            // The middle atom on a previous atom makes the cross product vanish.
            2:
            begin
                it.cur_x = it.prev_x; it.cur_y = it.prev_y; it.cur_z = it.prev_z;
            end
            default: ;
        endcase
        send_item(it, 1'b1);
    endtask

    // Drain the pipeline, then wait out its depth before touching registers.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (ltop_pkg::LAT_ORDER + 8) @(posedge clk);
    endtask

    // One write, then one quiet cycle so the enable drops before the next write.
    task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic make_item(output ltop_pkg::item_t it, input logic [23:0] px, py, pz,
                             cx, cy, cz, nx, ny, nz);
        it = '{px, py, pz, cx, cy, cz, nx, ny, nz};
    endtask

    task automatic run_directed();
        ltop_pkg::item_t it;
        // Straight bond along z with a bent middle atom.
        make_item(it, 0, 0, 0, 24'h10000, 0, 24'h8000, 0, 0, 24'h20000);
        send_item(it, 1'b0);
        // Previous equal to next: zero chain vector.
        make_item(it, 5, 6, 7, 1, 2, 3, 5, 6, 7);
        send_item(it, 1'b0);
        // Collinear atoms.
        make_item(it, 0, 0, 0, 1, 1, 1, 2, 2, 2);
        send_item(it, 1'b0);
        // Coordinates at the extremes of the fields, the second item mixed with zeros.
        make_item(it, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
                  24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_item(it, 1'b0);
        make_item(it, 24'h7FFFFF, 24'h800000, 0, 0, 24'h7FFFFF, 24'h800000,
                  24'h800000, 0, 24'h7FFFFF);
        send_item(it, 1'b0);
        // Bonds along x and y.
        make_item(it, 24'hFF0000, 0, 0, 0, 24'h10000, 0, 24'h10000, 0, 0);
        send_item(it, 1'b0);
        make_item(it, 0, 24'hFF0000, 0, 24'h10000, 0, 0, 0, 24'h10000, 0);
        send_item(it, 1'b0);
        // Negative midpoint, far outside the box.
        make_item(it, 24'hC00000, 24'hC00000, 24'hC00000, 3, 9, 1,
                  24'hC10000, 24'hC00100, 24'hC20000);
        send_item(it, 1'b0);
        make_item(it, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1, 0, 1, 2, 1);
        send_item(it, 1'b0);
    endtask

    initial
    begin
        logic [2:0]  axis;
        logic [8:0]  cnt;
        logic [22:0] len;
        rst_n = 1'b0;
        clk = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ltop_pkg::REG_NORMAL_AXIS;
        cfg_data = '0;
        steady = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first, then every axis with slicing off.
        run_directed();
        wait_idle();
        for (int a = 0; a < 4; a++)
        begin
            write_reg(ltop_pkg::REG_NORMAL_AXIS, 23'(a));
            run_directed();
            wait_idle();
        end
        // Slicing on with extreme and random settings.
        write_reg(ltop_pkg::REG_SLICING_ON, 23'd1);
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin axis = 2; cnt = 1;   len = 65536;       end
                1: begin axis = 0; cnt = 256; len = 23'h7FFFFF; end
                2: begin axis = 1; cnt = 0;   len = 0;           end
                3: begin axis = 3; cnt = 511; len = 1;           end
                4: begin axis = 2; cnt = 256; len = 300;         end
                default:
                begin
                    axis = 3'($urandom_range(3));
                    cnt = 9'($urandom_range(511));
                    len = 23'($urandom_range(23'h7FFFFF));
                end
            endcase
            write_reg(ltop_pkg::REG_NORMAL_AXIS, 23'(axis));
            write_reg(ltop_pkg::REG_SLICE_COUNT, 23'(cnt));
            write_reg(ltop_pkg::REG_BOX_LENGTH, len);
            if (ph == 0) run_directed();
            for (int i = 0; i < 95; i++)
            begin
                steady = (i >= 30 && i < 60);
                send_random();
            end
            steady = 1'b0;
            wait_idle();
        end
        write_reg(ltop_pkg::REG_SLICING_ON, 23'd0);
        for (int i = 0; i < 60; i++) send_random();
        wait_idle();

        $display("Covered %0d results (%0d degenerate) across all axes and slice settings.",
                 result_count, degen_count);
        if (fail_count == 0)
            $display("** lipid_tail_order_parameter: PASSED **");
        else
            $display("** lipid_tail_order_parameter: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** lipid_tail_order_parameter: FAILED **");
        $finish;
    end
endmodule
